// ===== sv/rsd_pkg.sv =====
// rsd_pkg: shared types and constants for the run-length screen decoder
// no dependencies; imported by the top level, rsd_front, rsd_back and the bench

package rsd_pkg;

    localparam int UNIT_BYTES   = 4;
    localparam int FRAME_W      = 25;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [FRAME_W-1:0] FRAME_UNITS_RESET = 25'd38400;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_UNITS = 2'd1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OPEN     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // unit record from the parser to the frame accounting stage
    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  want;
        logic        last;
        logic        end_open;
    } rsd_unit_t;

    // result as delivered on the output ports
    typedef struct packed {
        logic [31:0] unit_value;
        logic [7:0]  repeat_count;
        logic        frame_end;
        logic [1:0]  status;
    } rsd_result_t;

endpackage

// ===== sv/rle_screen_decoder.sv =====
// rle_screen_decoder: top level of the run-length screen decoder
// depends on rsd_pkg, rsd_fifo, rsd_front and rsd_back
//
// Usage:
//  - input is a queue: a compressed byte (data_byte, last) is taken on an edge
//    with push high and full low; last marks the final byte of the frame
//  - output is a queue: while empty is low the oldest result sits on
//    unit_value, repeat_count, frame_end and status; pop high takes it
//  - config: cfg_index 0 = unit_mode, 1 = frame_units; cfg_ready is always
//    high; write only while the decoder is idle
//  - one byte per cycle sustained while full is low; the parser handles one
//    beat per cycle and the frame accounting stage one per cycle while the
//    result queue is not full; the two are joined by a unit queue
//  - when pop stalls, the result queue fills, then the unit queue, then full
//    rises; nothing is dropped
//  - reset empties both queues, returns the parser to header state, clears
//    the frame unit count, unit_mode = 0, frame_units = 38400

module rle_screen_decoder
    import rsd_pkg::*;
#(
    parameter int UNIT_Q_DEPTH   = 4,
    parameter int RESULT_Q_DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             data_byte,
    input  logic                   last,
    output logic                   empty,
    input  logic                   pop,
    output logic [31:0]            unit_value,
    output logic [7:0]             repeat_count,
    output logic                   frame_end,
    output logic [1:0]             status,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [FRAME_W-1:0]     cfg_data
);

    localparam int UNIT_W   = $bits(rsd_unit_t);
    localparam int RESULT_W = $bits(rsd_result_t);

    logic               unit_mode_reg;
    logic [FRAME_W-1:0] frame_units_reg;
    logic               accept;
    logic               rec_push;
    rsd_unit_t          rec_in;
    rsd_unit_t          rec_out;
    logic [UNIT_W-1:0]  rec_out_bits;
    logic               unit_q_empty;
    logic               rec_pop;
    logic               res_full;
    logic               res_push;
    rsd_result_t        res_in;
    rsd_result_t        res_out;
    logic [RESULT_W-1:0] res_out_bits;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_mode_reg   <= 1'b0;
            frame_units_reg <= FRAME_UNITS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_UNIT_MODE)
            begin
                unit_mode_reg <= cfg_data[0];
            end
            else if (cfg_index == REG_FRAME_UNITS)
            begin
                frame_units_reg <= cfg_data;
            end
        end
    end

    rsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last      (last),
        .unit_mode (unit_mode_reg),
        .rec_push  (rec_push),
        .rec       (rec_in)
    );

    rsd_fifo #(
        .WIDTH (UNIT_W),
        .DEPTH (UNIT_Q_DEPTH)
    ) u_unit_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_push),
        .wdata (rec_in),
        .full  (full),
        .pop   (rec_pop),
        .rdata (rec_out_bits),
        .empty (unit_q_empty)
    );

    assign rec_out = rec_out_bits;

    rsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec_valid   (!unit_q_empty),
        .rec         (rec_out),
        .rec_pop     (rec_pop),
        .frame_units (frame_units_reg),
        .res_full    (res_full),
        .res_push    (res_push),
        .res         (res_in)
    );

    rsd_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (RESULT_Q_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out_bits),
        .empty (empty)
    );

    assign res_out      = res_out_bits;
    assign unit_value   = res_out.unit_value;
    assign repeat_count = res_out.repeat_count;
    assign frame_end    = res_out.frame_end;
    assign status       = res_out.status;

    // an open-block status only comes with the end of a frame
    a_open_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_OPEN) |-> frame_end)
        else $error("open-block status without frame end");

    // a clean result with no unit is only the status beat of a frame end
    a_zero_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_OK && !frame_end) |-> (repeat_count != 8'd0))
        else $error("ok result with zero repeat count mid frame");

    // repeat count never exceeds the longest repeat block
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (repeat_count <= 8'd128))
        else $error("repeat count out of range");

    // results leave the back stage only when the result queue has room
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

endmodule

// ===== sv/rsd_fifo.sv =====
// rsd_fifo: small first-word-fall-through queue on a register array
// no package dependency; used for the unit queue and the result queue

module rsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/rsd_front.sv =====
// rsd_front: byte parser; tracks block headers and assembles units
// depends on rsd_pkg; feeds unit records to the unit queue

module rsd_front
    import rsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic [7:0] data_byte,
    input  logic      last,
    input  logic      unit_mode,
    output logic      rec_push,
    output rsd_unit_t rec
);

    typedef enum logic [2:0] {
        PH_HEADER   = 3'b001,
        PH_REPEAT   = 3'b010,
        PH_VERBATIM = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  units_left_reg, units_left_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [23:0] partial_reg, partial_next;
    logic        done;
    logic [31:0] value;
    logic [7:0]  want;
    logic        in_block;
    logic        end_open;

    assign in_block = (phase_reg == PH_REPEAT) || (phase_reg == PH_VERBATIM);

    always_comb
    begin
        phase_next      = phase_reg;
        units_left_next = units_left_reg;
        byte_idx_next   = byte_idx_reg;
        partial_next    = partial_reg;
        done            = 1'b0;
        value           = '0;
        want            = '0;
        end_open        = 1'b0;
        if (accept)
        begin
            if (!in_block)
            begin
                // low half opens a repeat block, high half a verbatim block
                if (data_byte[7])
                begin
                    units_left_next = ~data_byte + 8'd2;
                    phase_next      = PH_VERBATIM;
                end
                else
                begin
                    units_left_next = data_byte + 8'd1;
                    phase_next      = PH_REPEAT;
                end
                byte_idx_next = '0;
                partial_next  = '0;
            end
            else
            begin
                if (!unit_mode)
                begin
                    value = {24'd0, data_byte};
                    done  = 1'b1;
                end
                else if (byte_idx_reg != 2'(UNIT_BYTES - 1))
                begin
                    case (byte_idx_reg)
                        2'd0:    partial_next[7:0]   = data_byte;
                        2'd1:    partial_next[15:8]  = data_byte;
                        default: partial_next[23:16] = data_byte;
                    endcase
                    byte_idx_next = byte_idx_reg + 2'd1;
                end
                else
                begin
                    value = {data_byte, partial_reg};
                    done  = 1'b1;
                end
                if (done)
                begin
                    if (phase_reg == PH_REPEAT)
                    begin
                        want            = units_left_reg;
                        units_left_next = '0;
                    end
                    else
                    begin
                        want            = 8'd1;
                        units_left_next = (units_left_reg != '0) ? units_left_reg - 8'd1 : '0;
                    end
                    if (units_left_next == '0)
                    begin
                        phase_next = PH_HEADER;
                    end
                    byte_idx_next = '0;
                    partial_next  = '0;
                end
            end
            end_open = last && ((phase_next != PH_HEADER) || (byte_idx_next != '0));
            if (last)
            begin
                phase_next      = PH_HEADER;
                units_left_next = '0;
                byte_idx_next   = '0;
                partial_next    = '0;
            end
        end
    end

    assign rec_push     = accept && (done || last);
    assign rec.value    = value;
    assign rec.want     = want;
    assign rec.last     = last;
    assign rec.end_open = end_open;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            units_left_reg <= '0;
            byte_idx_reg   <= '0;
            partial_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            units_left_reg <= units_left_next;
            byte_idx_reg   <= byte_idx_next;
            partial_reg    <= partial_next;
        end
    end

endmodule

// ===== sv/rsd_back.sv =====
// rsd_back: frame accounting; clips repeat counts to the room left in the frame
// depends on rsd_pkg; takes unit records, pushes results to the result queue

module rsd_back
    import rsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    input  rsd_unit_t          rec,
    output logic               rec_pop,
    input  logic [FRAME_W-1:0] frame_units,
    input  logic               res_full,
    output logic               res_push,
    output rsd_result_t        res
);

    logic [FRAME_W-1:0] written_reg, written_next;
    logic [FRAME_W:0]   sum;
    logic [FRAME_W-1:0] diff;
    logic               fits;
    logic               room_left;
    logic [7:0]         give;

    assign rec_pop  = rec_valid && !res_full;
    assign res_push = rec_pop;

    // sum and remaining room are formed side by side, not in series
    assign sum       = {1'b0, written_reg} + {{(FRAME_W - 7){1'b0}}, rec.want};
    assign diff      = frame_units - written_reg;
    assign room_left = frame_units > written_reg;
    assign fits      = (rec.want == '0) || (sum <= {1'b0, frame_units});

    always_comb
    begin
        written_next = written_reg;
        give         = rec.want;
        if (!fits)
        begin
            // room is below want here, so it fits in the count width
            give = room_left ? diff[7:0] : '0;
        end
        if (rec_pop)
        begin
            if (rec.last)
            begin
                written_next = '0;
            end
            else if (fits)
            begin
                written_next = sum[FRAME_W-1:0];
            end
            else if (room_left)
            begin
                written_next = frame_units;
            end
        end
    end

    assign res.unit_value   = rec.value;
    assign res.repeat_count = give;
    assign res.frame_end    = rec.last;
    assign res.status       = rec.end_open ? ST_OPEN : (fits ? ST_OK : ST_OVERFLOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else
        begin
            written_reg <= written_next;
        end
    end

endmodule

// ===== tb/rle_screen_decoder_tb.sv =====
// rle_screen_decoder_tb: self-checking bench for the run-length screen decoder
// depends on rsd_pkg and rle_screen_decoder; directed frames first, then random
// frames under several register settings, checked against a behavioral decoder

module rle_screen_decoder_tb;
    import rsd_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int TIMEOUT_CYCLES = 300000;
    localparam int PHASE_BYTES    = 220;

    typedef enum logic [1:0] {STEP_BYTE, STEP_CFG, STEP_DRAIN} step_kind_t;
    typedef enum logic [1:0] {SEEK_HEADER, IN_REPEAT, IN_LITERAL} dec_phase_t;

    typedef struct packed {
        step_kind_t             kind;
        logic [7:0]             data;
        logic                   lst;
        logic [CFG_INDEX_W-1:0] idx;
        logic [FRAME_W-1:0]     wdata;
    } stim_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [7:0]             data_byte = '0;
    logic                   last = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [31:0]            unit_value;
    logic [7:0]             repeat_count;
    logic                   frame_end;
    logic [1:0]             status;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [FRAME_W-1:0]     cfg_data = '0;

    stim_t       stream_q[$];
    rsd_result_t due_results[$];
    int          byte_cnt = 0;
    int          fail_cnt = 0;
    int          cyc = 0;
    int          settle_cnt = 0;
    bit          byte_taken = 1'b0;
    bit          cfg_taken = 1'b0;

    // register copies and decoder state of the predictor
    logic               cfg_mode = 1'b0;
    logic [FRAME_W-1:0] cfg_frame = FRAME_UNITS_RESET;
    dec_phase_t         dec_phase = SEEK_HEADER;
    logic [7:0]         dec_left = '0;
    logic [1:0]         dec_byte_idx = '0;
    logic [23:0]        dec_partial = '0;
    logic [FRAME_W-1:0] dec_written = '0;

    rle_screen_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .last         (last),
        .empty        (empty),
        .pop          (pop),
        .unit_value   (unit_value),
        .repeat_count (repeat_count),
        .frame_end    (frame_end),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void decode_byte(input logic [7:0] b, input logic lst);
        rsd_result_t        r;
        logic               done;
        logic [7:0]         want;
        logic [FRAME_W-1:0] room;
        logic [FRAME_W-1:0] give;
        r = '0;
        done = 1'b0;
        want = '0;
        if (dec_phase == SEEK_HEADER)
        begin
            if (!b[7])
            begin
                dec_left = 8'(int'(b) + 1);
                dec_phase = IN_REPEAT;
            end
            else
            begin
                dec_left = 8'(257 - int'(b));
                dec_phase = IN_LITERAL;
            end
            dec_byte_idx = '0;
            dec_partial = '0;
        end
        else
        begin
            if (!cfg_mode)
            begin
                r.unit_value = {24'd0, b};
                done = 1'b1;
            end
            else if (dec_byte_idx < UNIT_BYTES - 1)
            begin
                dec_partial[8*dec_byte_idx +: 8] = b;
                dec_byte_idx++;
            end
            else
            begin
                r.unit_value = {b, dec_partial};
                done = 1'b1;
            end
            if (done)
            begin
                if (dec_phase == IN_REPEAT)
                begin
                    want = dec_left;
                    dec_left = '0;
                end
                else
                begin
                    want = 8'd1;
                    dec_left = (dec_left != 0) ? dec_left - 8'd1 : 8'd0;
                end
                if (dec_left == 0)
                    dec_phase = SEEK_HEADER;
                dec_byte_idx = '0;
                dec_partial = '0;
                room = (cfg_frame > dec_written) ? cfg_frame - dec_written : '0;
                give = (want < room) ? FRAME_W'(want) : room;
                dec_written += give;
                r.repeat_count = give[7:0];
                if (give < want)
                    r.status = ST_OVERFLOW;
            end
        end
        if (done || lst)
        begin
            // an open block or a half-built word outranks overflow
            if (lst && (dec_phase != SEEK_HEADER || dec_byte_idx != 0))
                r.status = ST_OPEN;
            r.frame_end = lst;
            due_results.push_back(r);
            if (lst)
            begin
                dec_phase = SEEK_HEADER;
                dec_left = '0;
                dec_byte_idx = '0;
                dec_partial = '0;
                dec_written = '0;
            end
        end
    endfunction

    function automatic bit calm_stretch();
        return cyc >= 800 && cyc < 1400;
    endfunction

    function automatic bit take_break();
        return !calm_stretch() && $urandom_range(0, 99) < 18;
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic lst);
        stim_t s;
        s = '0;
        s.kind = STEP_BYTE;
        s.data = b;
        s.lst = lst;
        stream_q.push_back(s);
        byte_cnt++;
    endtask

    task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [FRAME_W-1:0] val);
        stim_t s;
        s = '0;
        s.kind = STEP_CFG;
        s.idx = idx;
        s.wdata = val;
        stream_q.push_back(s);
    endtask

    task automatic add_drain();
        stim_t s;
        s = '0;
        s.kind = STEP_DRAIN;
        stream_q.push_back(s);
    endtask

    // mostly whole frames, some cut short, some plain noise
    task automatic add_frame(input bit wide);
        logic [7:0] fb[$];
        int         nblk;
        int         cnt;
        int         cut;
        int         shape;
        shape = $urandom_range(0, 99);
        if (shape >= 90)
        begin
            cnt = $urandom_range(1, 8);
            for (int i = 0; i < cnt; i++)
                add_byte(8'($urandom), i == cnt - 1 || $urandom_range(0, 3) == 0);
            return;
        end
        nblk = $urandom_range(1, 4);
        for (int k = 0; k < nblk; k++)
        begin
            if ($urandom_range(0, 1))
            begin
                fb.push_back(8'($urandom_range(0, 127)));
                cnt = 1;
            end
            else
            begin
                cnt = ($urandom_range(0, 29) == 0) ? $urandom_range(2, 129)
                                                    : $urandom_range(2, 6);
                fb.push_back(8'(257 - cnt));
            end
            for (int u = 0; u < cnt * (wide ? UNIT_BYTES : 1); u++)
                fb.push_back(8'($urandom));
        end
        cut = (shape < 75) ? fb.size() : $urandom_range(1, fb.size());
        for (int i = 0; i < cut; i++)
            add_byte(fb[i], i == cut - 1);
    endtask

    // driver: one beat per head entry, changes on the falling edge
    always @(negedge clk)
    begin : feed
        stim_t head;
        logic  nxt_push;
        logic  nxt_cfg;
        nxt_push = 1'b0;
        nxt_cfg = 1'b0;
        if (rst_n)
        begin
            cyc++;
            if (byte_taken || cfg_taken)
                stream_q.delete(0);
            if (stream_q.size() != 0)
            begin
                head = stream_q[0];
                case (head.kind)
                    STEP_BYTE:
                        nxt_push = (push && !byte_taken) || !take_break();
                    STEP_CFG:
                        nxt_cfg = 1'b1;
                    STEP_DRAIN:
                    begin
                        // a byte with no result may still be in flight
                        if (due_results.size() != 0)
                            settle_cnt = 0;
                        else if (settle_cnt == SETTLE_CYCLES)
                        begin
                            settle_cnt = 0;
                            stream_q.delete(0);
                        end
                        else
                            settle_cnt++;
                    end
                    default: ;
                endcase
                data_byte <= head.data;
                last <= head.lst;
                cfg_index <= head.idx;
                cfg_data <= head.wdata;
            end
            pop <= calm_stretch() ? 1'b1 : ($urandom_range(0, 99) >= 18);
        end
        push <= nxt_push;
        cfg_valid <= nxt_cfg;
    end

    // monitor: samples the pop, config and push handshakes on the rising edge
    always @(posedge clk)
    begin : watch
        rsd_result_t due;
        byte_taken = 1'b0;
        cfg_taken = 1'b0;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with none pending: unit_value %h repeat_count %0d",
                           unit_value, repeat_count);
                    fail_cnt++;
                end
                else
                begin
                    due = due_results.pop_front();
                    if (unit_value !== due.unit_value)
                    begin
                        $error("unit_value: expected %h, got %h", due.unit_value, unit_value);
                        fail_cnt++;
                    end
                    if (repeat_count !== due.repeat_count)
                    begin
                        $error("repeat_count: expected %0d, got %0d",
                               due.repeat_count, repeat_count);
                        fail_cnt++;
                    end
                    if (frame_end !== due.frame_end)
                    begin
                        $error("frame_end: expected %0d, got %0d", due.frame_end, frame_end);
                        fail_cnt++;
                    end
                    if (status !== due.status)
                    begin
                        $error("status: expected %0d, got %0d", due.status, status);
                        fail_cnt++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_UNIT_MODE)
                    cfg_mode = cfg_data[0];
                else if (cfg_index == REG_FRAME_UNITS)
                    cfg_frame = cfg_data;
                cfg_taken = 1'b1;
            end
            if (push && !full)
            begin
                decode_byte(data_byte, last);
                byte_taken = 1'b1;
            end
        end
    end

    initial
    begin : plan
        logic [FRAME_W-1:0] fu;
        int                 phase_end;
        // one-byte units at reset settings
        add_byte(8'h00, 1'b0);
        add_byte(8'hAA, 1'b1);
        add_byte(8'h7F, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h55, 1'b1);
        // frame ends on a header byte
        add_byte(8'h80, 1'b1);
        // frame ends inside a literal block
        add_byte(8'hFE, 1'b0);
        add_byte(8'h11, 1'b0);
        add_byte(8'h22, 1'b1);
        add_drain();
        add_cfg(REG_UNIT_MODE, 25'd1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h03, 1'b0);
        add_byte(8'h04, 1'b1);
        // switch to one-byte units with half a word built
        add_byte(8'hFF, 1'b0);
        add_byte(8'h10, 1'b0);
        add_byte(8'h20, 1'b0);
        add_drain();
        add_cfg(REG_UNIT_MODE, 25'd0);
        add_byte(8'h33, 1'b0);
        add_byte(8'h44, 1'b1);
        // no room at all, then room for a single unit
        add_drain();
        add_cfg(REG_FRAME_UNITS, 25'd0);
        add_byte(8'h03, 1'b0);
        add_byte(8'h99, 1'b1);
        add_drain();
        add_cfg(REG_FRAME_UNITS, 25'd1);
        add_byte(8'h02, 1'b0);
        add_byte(8'h77, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h88, 1'b1);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: fu = FRAME_UNITS_RESET;
                1: fu = FRAME_W'($urandom_range(8, 64));
                2: fu = '0;
                3: fu = '1;
                4: fu = FRAME_W'($urandom_range(1, 40));
                5: fu = 25'd16777216;
                6: fu = 25'd1;
                default: fu = FRAME_W'($urandom_range(100, 400));
            endcase
            add_drain();
            add_cfg(REG_UNIT_MODE, FRAME_W'(p % 2));
            add_cfg(REG_FRAME_UNITS, fu);
            phase_end = byte_cnt + PHASE_BYTES;
            while (byte_cnt < phase_end)
                add_frame(p % 2 == 1);
        end

        // reset is held from the start, then released on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (stream_q.size() != 0 || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 10);
        $display("Test completed with failures");
        $finish;
    end

endmodule
